[sv/b30p_pkg.sv]
// Shared types and constants for the base-30 number token parser.
// No dependencies; imported by every module of the block.
package b30p_pkg;

  localparam int CHAR_W = 8;
  localparam int DIG_W  = 5;
  localparam int KIND_W = 2;
  localparam int MANT_W = 64;
  localparam int EXP_W  = 16;
  localparam int TDATA_OUT_W = 88;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UT    = 8'h54;
  localparam logic [DIG_W-1:0]  DIG_TEN  = 5'd10;

  typedef enum logic [2:0] {
    CL_DIGIT,
    CL_SPACE,
    CL_STAR,
    CL_MINUS,
    CL_PLUS,
    CL_POINT,
    CL_SLASH,
    CL_OTHER
  } cls_t;

  typedef struct packed {
    cls_t             cls;
    logic [DIG_W-1:0] dval;
  } tok_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MISS,
    PH_MANT,
    PH_EXP
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NUMBER,
    KIND_MISSING,
    KIND_NO_DIGITS,
    KIND_NO_TERM
  } kind_t;

  function automatic tok_t classify(input logic [CHAR_W-1:0] c);
    tok_t t;
    t.dval = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t.cls  = CL_DIGIT;
      t.dval = DIG_W'(c - CH_ZERO);
    end else if (c >= CH_UA && c <= CH_UT) begin
      t.cls  = CL_DIGIT;
      t.dval = DIG_W'(c - CH_UA) + DIG_TEN;
    end else begin
      case (c)
        CH_SPACE: t.cls = CL_SPACE;
        CH_STAR:  t.cls = CL_STAR;
        CH_MINUS: t.cls = CL_MINUS;
        CH_PLUS:  t.cls = CL_PLUS;
        CH_POINT: t.cls = CL_POINT;
        CH_SLASH: t.cls = CL_SLASH;
        default:  t.cls = CL_OTHER;
      endcase
    end
    return t;
  endfunction

endpackage

[sv/b30p_front.sv]
// Front end: takes character requests and classifies them into tokens.
// Depends on b30p_pkg; feeds b30p_queue.
module b30p_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_char,
  output logic                    out_valid,
  input  logic                    out_ready,
  output b30p_pkg::tok_t          out_tok
);
  import b30p_pkg::*;

  logic valid;
  logic valid_next;
  tok_t tok;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_tok   = tok;

  always_comb begin
    valid_next = valid;
    if (in_valid && in_ready) begin
      valid_next = 1'b1;
    end else if (out_ready) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tok <= classify(in_char);
    end
  end

endmodule

[sv/b30p_queue.sv]
// Short token queue between the front end and the parser.
// Depends on b30p_pkg.
module b30p_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  b30p_pkg::tok_t in_tok,
  output logic           out_valid,
  input  logic           out_ready,
  output b30p_pkg::tok_t out_tok
);
  import b30p_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  tok_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign in_ready  = (count != FULL);
  assign out_valid = (count != '0);
  assign out_tok   = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_tok;
    end
  end

endmodule

[sv/b30p_back.sv]
// Back end: token parser state machine and the result register.
// Depends on b30p_pkg; consumes tokens from b30p_queue.
module b30p_back #(
  parameter int MANT_BITS = 64,
  parameter int EXP_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  b30p_pkg::tok_t                 in_tok,
  output logic                           out_valid,
  input  logic                           out_ready,
  output b30p_pkg::kind_t                out_kind,
  output logic                           out_negative,
  output logic [b30p_pkg::MANT_W-1:0]    out_mantissa,
  output logic [b30p_pkg::EXP_W-1:0]     out_exponent
);
  import b30p_pkg::*;

  localparam int SW = EXP_BITS + 2;
  localparam int EW = EXP_BITS + 5;
  localparam logic [MANT_BITS-1:0] MANT_LIM = ({MANT_BITS{1'b1}} - 29) / 30;
  localparam logic signed [SW-1:0] S_HI = (SW'(1) <<< (EXP_BITS - 1)) - 1;
  localparam logic signed [SW-1:0] S_LO = -S_HI - 1;
  localparam logic [EXP_BITS-2:0]  E_HI = {(EXP_BITS-1){1'b1}};

  function automatic logic signed [EXP_BITS-1:0] clamp_s(input logic signed [SW-1:0] v);
    if (v > S_HI) begin
      return EXP_BITS'(S_HI);
    end else if (v < S_LO) begin
      return EXP_BITS'(S_LO);
    end
    return EXP_BITS'(v);
  endfunction

  phase_t                      phase, phase_next;
  logic [MANT_BITS-1:0]        mant, mant_next;
  logic signed [EXP_BITS-1:0]  scale, scale_next;
  logic [EXP_BITS-2:0]         expa, expa_next;
  logic                        seen_point, seen_point_next;
  logic                        seen_digit, seen_digit_next;
  logic                        sign_neg, sign_neg_next;
  logic                        exp_neg, exp_neg_next;

  logic                        pop;
  logic                        emit;
  logic                        term;
  kind_t                       e_kind;
  logic                        e_neg;
  logic [MANT_BITS-1:0]        e_mant;
  logic signed [EXP_BITS-1:0]  e_exp;

  logic                        full;
  logic [MANT_BITS-1:0]        dig_mant;
  logic signed [EXP_BITS-1:0]  s1;
  logic signed [EXP_BITS-1:0]  dig_scale;
  logic [EW-1:0]               ew;
  logic [EXP_BITS-2:0]         dig_exp;
  logic signed [SW-1:0]        exp_s;
  logic signed [SW-1:0]        net;

  logic                        ovalid;
  kind_t                       okind;
  logic                        oneg;
  logic [MANT_BITS-1:0]        omant;
  logic signed [EXP_BITS-1:0]  oexp;

  assign in_ready = !ovalid || out_ready;
  assign pop      = in_valid && in_ready;

  // digit into the mantissa, or into the scale once the mantissa is full
  assign full     = (mant > MANT_LIM);
  assign dig_mant = (mant << 5) - (mant << 1) + MANT_BITS'(in_tok.dval);
  assign s1       = full ? clamp_s(SW'(scale) + SW'(1)) : scale;
  assign dig_scale = seen_point ? clamp_s(SW'(s1) - SW'(1)) : s1;

  assign ew      = (EW'(expa) << 5) - (EW'(expa) << 1) + EW'(in_tok.dval);
  assign dig_exp = (ew > EW'(E_HI)) ? E_HI : ew[EXP_BITS-2:0];

  assign exp_s = SW'(signed'({1'b0, expa}));
  assign net   = SW'(scale) + (exp_neg ? -exp_s : exp_s);

  always_comb begin
    phase_next      = phase;
    mant_next       = mant;
    scale_next      = scale;
    expa_next       = expa;
    seen_point_next = seen_point;
    seen_digit_next = seen_digit;
    sign_neg_next   = sign_neg;
    exp_neg_next    = exp_neg;
    emit   = 1'b0;
    term   = 1'b0;
    e_kind = KIND_NUMBER;
    e_neg  = 1'b0;
    e_mant = '0;
    e_exp  = '0;

    if (pop) begin
      case (phase)
        PH_IDLE: begin
          case (in_tok.cls)
            CL_SPACE: ;
            CL_STAR: phase_next = PH_MISS;
            CL_MINUS: begin
              phase_next    = PH_MANT;
              sign_neg_next = 1'b1;
            end
            CL_DIGIT: begin
              phase_next      = PH_MANT;
              seen_digit_next = 1'b1;
              mant_next       = full ? mant : dig_mant;
              scale_next      = dig_scale;
            end
            CL_POINT: begin
              phase_next      = PH_MANT;
              seen_point_next = 1'b1;
            end
            default: begin
              emit   = 1'b1;
              e_kind = KIND_NO_DIGITS;
            end
          endcase
        end
        PH_MISS: begin
          emit   = 1'b1;
          e_kind = KIND_MISSING;
        end
        PH_MANT: begin
          if (in_tok.cls == CL_DIGIT) begin
            seen_digit_next = 1'b1;
            mant_next       = full ? mant : dig_mant;
            scale_next      = dig_scale;
          end else if (!seen_point && in_tok.cls == CL_POINT) begin
            seen_point_next = 1'b1;
          end else if (!seen_digit) begin
            emit   = 1'b1;
            e_kind = KIND_NO_DIGITS;
          end else if (in_tok.cls == CL_PLUS || in_tok.cls == CL_MINUS) begin
            exp_neg_next = (in_tok.cls == CL_MINUS);
            phase_next   = PH_EXP;
          end else begin
            term = 1'b1;
          end
        end
        PH_EXP: begin
          if (in_tok.cls == CL_DIGIT) begin
            expa_next = dig_exp;
          end else begin
            term = 1'b1;
          end
        end
        default: ;
      endcase

      if (term) begin
        emit = 1'b1;
        if (in_tok.cls == CL_SLASH) begin
          e_kind = KIND_NUMBER;
          e_neg  = sign_neg;
          e_mant = mant;
          e_exp  = clamp_s(net);
        end else begin
          e_kind = KIND_NO_TERM;
        end
      end

      if (emit) begin
        phase_next      = PH_IDLE;
        mant_next       = '0;
        scale_next      = '0;
        expa_next       = '0;
        seen_point_next = 1'b0;
        seen_digit_next = 1'b0;
        sign_neg_next   = 1'b0;
        exp_neg_next    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      mant       <= '0;
      scale      <= '0;
      expa       <= '0;
      seen_point <= 1'b0;
      seen_digit <= 1'b0;
      sign_neg   <= 1'b0;
      exp_neg    <= 1'b0;
    end else begin
      phase      <= phase_next;
      mant       <= mant_next;
      scale      <= scale_next;
      expa       <= expa_next;
      seen_point <= seen_point_next;
      seen_digit <= seen_digit_next;
      sign_neg   <= sign_neg_next;
      exp_neg    <= exp_neg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (pop && emit) begin
      ovalid <= 1'b1;
    end else if (out_ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      okind <= e_kind;
      oneg  <= e_neg;
      omant <= e_mant;
      oexp  <= e_exp;
    end
  end

  assign out_valid    = ovalid;
  assign out_kind     = okind;
  assign out_negative = oneg;
  assign out_mantissa = MANT_W'(omant);
  assign out_exponent = EXP_W'(32'(oexp));

endmodule

[sv/base30_number_token_parser.sv]
// Top level of the base-30 number token parser.
// Depends on b30p_pkg, b30p_front, b30p_queue and b30p_back.
//
//  channel  dir  fields
//  s_axis   in   tdata[7:0] char_code
//  m_axis   out  tuser[1:0] kind; tdata negative, mantissa, exponent
//
// One character request per cycle, with no bubbles, until a stalled result fills the token queue.
// A result is presented after the request ending its token has passed the classifier
// register, then the token queue, and then the parser and result register.
// rst clears the parser to idle skipping spaces and empties the token queue.
// A stalled result holds the parser only; the classifier and queue keep taking requests
// until the queue is full and the classifier register holds a token, and then s_axis_tready drops.
module base30_number_token_parser #(
  parameter int MANT_BITS   = 64,
  parameter int EXP_BITS    = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // [0] negative, [64:1] mantissa, [80:65] exponent
  output logic [1:0]  m_axis_tuser    // [1:0] kind
);
  import b30p_pkg::*;

  logic  f_valid;
  logic  f_ready;
  tok_t  f_tok;
  logic  q_valid;
  logic  q_ready;
  tok_t  q_tok;
  kind_t o_kind;
  logic  o_neg;
  logic [MANT_W-1:0] o_mant;
  logic [EXP_W-1:0]  o_exp;

  b30p_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_char   (s_axis_tdata),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_tok   (f_tok)
  );

  b30p_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_tok    (f_tok),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_tok   (q_tok)
  );

  b30p_back #(
    .MANT_BITS (MANT_BITS),
    .EXP_BITS  (EXP_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (q_valid),
    .in_ready     (q_ready),
    .in_tok       (q_tok),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_kind     (o_kind),
    .out_negative (o_neg),
    .out_mantissa (o_mant),
    .out_exponent (o_exp)
  );

  assign m_axis_tuser = o_kind;
  assign m_axis_tdata = TDATA_OUT_W'({o_exp, o_mant, o_neg});

endmodule
